@@ rtl/pol_pkg.sv @@
// Shared types and codes for the positional ordered list unit.
package pol_pkg;

    // Action codes carried in the input word
    localparam logic [2:0] ACT_INSERT     = 3'd0;
    localparam logic [2:0] ACT_REMOVE_POS = 3'd1;
    localparam logic [2:0] ACT_REMOVE_VAL = 3'd2;
    localparam logic [2:0] ACT_UPDATE     = 3'd3;
    localparam logic [2:0] ACT_READ       = 3'd4;
    localparam logic [2:0] ACT_FIND       = 3'd5;
    localparam logic [2:0] ACT_CLEAR      = 3'd6;

    // Status codes carried in the result word
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // found_index when there is no match
    localparam logic [4:0] NO_INDEX = 5'h1F;

    // Per-cell operation for the next clock edge
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LOAD  = 2'd1;  // take the key
    localparam logic [1:0] CELL_LOWER = 2'd2;  // take the lower neighbor (insert shift)
    localparam logic [1:0] CELL_UPPER = 2'd3;  // take the upper neighbor (delete shift)

    typedef struct packed {
        logic [1:0] op;
        logic       live;   // cell holds a list entry
    } t_cell_ctl;

endpackage

@@ rtl/pol_cell.sv @@
// One list cell: holds an entry, shifts to/from its neighbors, compares against the key.
module pol_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  pol_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_lower,
    input  logic [DATA_WIDTH-1:0] i_upper,
    input  logic                  i_hit,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit,
    output logic                  o_first
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_match;

    assign w_match = i_ctl.live && (r_data == i_key);
    assign o_first = w_match && !i_hit;
    assign o_hit   = w_match || i_hit;
    assign o_data  = r_data;

    always_comb begin
        case (i_ctl.op)
            pol_pkg::CELL_LOAD:  n_data = i_key;
            pol_pkg::CELL_LOWER: n_data = i_lower;
            pol_pkg::CELL_UPPER: n_data = i_upper;
            default:             n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

@@ rtl/positional_ordered_list_unit.sv @@
// Top level of the positional ordered list: action decode, cell chain, result register.
//
//  channel | dir | word                                              | bits
//  --------+-----+---------------------------------------------------+-----
//  s       | in  | action, at_end, position, value                   | 40
//  m       | out | success, status, read_value, found_index, total   | 48
//
//  Each action is decoded and applied to the cell chain in the cycle it is
//  accepted, and its result is registered for the m side. One action per
//  clock is sustained while the m side takes results; the match compare
//  runs in every cell at once and the first match ripples up the chain.
//  A stalled result holds o_m_tdata and drops o_s_tready.
//  Reset (i_rst_n low, synchronous) empties the list and drops o_m_tvalid.
module positional_ordered_list_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // action[2:0], at_end[3], position[7:4], value[39:8]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // success[0], status[3:1], read_value[35:4],
                                     // found_index[40:36], entry_total[45:41], zero[47:46]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;   // common compare width

    // Input word fields
    logic [2:0]            w_action;
    logic                  w_at_end;
    logic [3:0]            w_pos;
    logic [31:0]           w_value;
    logic [DATA_WIDTH-1:0] w_key;
    logic                  w_accept;

    assign w_action = i_s_tdata[2:0];
    assign w_at_end = i_s_tdata[3];
    assign w_pos    = i_s_tdata[7:4];
    assign w_value  = i_s_tdata[39:8];

    // Fit the value to the stored width
    generate
        if (DATA_WIDTH == 32) begin : g_key_eq
            assign w_key = w_value;
        end else if (DATA_WIDTH < 32) begin : g_key_nar
            assign w_key = w_value[DATA_WIDTH-1:0];
        end else begin : g_key_wide
            assign w_key = {{(DATA_WIDTH-32){1'b0}}, w_value};
        end
    endgenerate

    // Control state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic [47:0]   r_out_data;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Cell chain wiring
    logic [DATA_WIDTH-1:0] w_data  [CAPACITY];
    logic [CAPACITY:0]     w_hit;
    logic [CAPACITY-1:0]   w_first;
    pol_pkg::t_cell_ctl    w_ctl   [CAPACITY];

    assign w_hit[0] = 1'b0;

    // Decode results shared by all cells
    logic [XW-1:0] w_count_x;
    logic [XW-1:0] w_pos_x;
    logic [XW-1:0] w_ins_pos;
    logic [XW-1:0] w_del_pos;
    logic          w_do_insert;
    logic          w_do_del_pos;
    logic          w_do_del_val;
    logic          w_do_update;
    logic          w_empty;
    logic          w_full;
    logic          w_pos_ok;
    logic          w_any_hit;
    logic          w_success;
    logic [2:0]    w_status;
    logic [31:0]   w_rd;
    logic [4:0]    w_fidx;
    logic [XW-1:0] w_first_idx;
    logic [DATA_WIDTH-1:0] w_sel;
    logic [31:0]   w_sel32;

    assign w_count_x = XW'(r_count);
    assign w_pos_x   = XW'(w_pos);
    assign w_empty   = (r_count == '0);
    assign w_full    = (w_count_x == XW'(CAPACITY));
    assign w_pos_ok  = (w_pos_x < w_count_x);
    assign w_any_hit = w_hit[CAPACITY];
    assign w_ins_pos = (w_at_end || !w_pos_ok) ? w_count_x : w_pos_x;
    assign w_del_pos = w_at_end ? (w_count_x - XW'(1)) : w_pos_x;

    // Read mux and first-match index; cells are independent here
    always_comb begin
        w_sel       = '0;
        w_first_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_pos_x == XW'(i)) begin
                w_sel = w_data[i];
            end
            if (w_first[i]) begin
                w_first_idx = w_first_idx | XW'(i);
            end
        end
    end

    // Fit the stored entry to the 32-bit read field: sign-extend a narrower one, keep the low 32 bits of a wider one
    generate
        if (DATA_WIDTH >= 32) begin : g_rd_wide
            assign w_sel32 = w_sel[31:0];
        end else begin : g_rd_nar
            assign w_sel32 = {{(32-DATA_WIDTH){w_sel[DATA_WIDTH-1]}}, w_sel};
        end
    endgenerate

    // Action decode
    always_comb begin
        n_count      = r_count;
        w_success    = 1'b1;
        w_status     = pol_pkg::ST_OK;
        w_rd         = '0;
        w_fidx       = pol_pkg::NO_INDEX;
        w_do_insert  = 1'b0;
        w_do_del_pos = 1'b0;
        w_do_del_val = 1'b0;
        w_do_update  = 1'b0;
        unique case (w_action) inside
            pol_pkg::ACT_INSERT: begin
                if (w_full) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_FULL;
                end else begin
                    w_do_insert = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            pol_pkg::ACT_REMOVE_POS: begin
                if (w_empty) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_EMPTY;
                end else if (!w_at_end && !w_pos_ok) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_RANGE;
                end else begin
                    w_do_del_pos = 1'b1;
                    n_count      = r_count - CW'(1);
                end
            end
            pol_pkg::ACT_REMOVE_VAL: begin
                if (w_empty) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_EMPTY;
                end else if (!w_any_hit) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_NOTFOUND;
                end else begin
                    w_do_del_val = 1'b1;
                    n_count      = r_count - CW'(1);
                end
            end
            pol_pkg::ACT_UPDATE, pol_pkg::ACT_READ: begin
                if (w_empty) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_RANGE;
                end else if (w_action == pol_pkg::ACT_UPDATE) begin
                    w_do_update = 1'b1;
                end else begin
                    w_rd = w_sel32;
                end
            end
            pol_pkg::ACT_FIND: begin
                if (w_empty) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_EMPTY;
                end else if (!w_any_hit) begin
                    w_success = 1'b0;
                    w_status  = pol_pkg::ST_NOTFOUND;
                end else begin
                    w_fidx = w_first_idx[4:0];
                end
            end
            pol_pkg::ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused action code: leave the list alone, report ok
            end
        endcase
    end

    // Cell chain: each cell gets its own operation from the decode
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam logic [XW-1:0] IDX  = XW'(gi);
            localparam logic [XW-1:0] IDX1 = XW'(gi + 1);

            logic [DATA_WIDTH-1:0] w_lower;
            logic [DATA_WIDTH-1:0] w_upper;

            if (gi == 0) begin : g_lo_end
                assign w_lower = '0;
            end else begin : g_lo_mid
                assign w_lower = w_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_hi_end
                assign w_upper = '0;
            end else begin : g_hi_mid
                assign w_upper = w_data[gi+1];
            end

            always_comb begin
                w_ctl[gi].live = (IDX < w_count_x);
                w_ctl[gi].op   = pol_pkg::CELL_HOLD;
                if (w_accept) begin
                    if (w_do_insert) begin
                        if (IDX == w_ins_pos) begin
                            w_ctl[gi].op = pol_pkg::CELL_LOAD;
                        end else if (IDX > w_ins_pos && IDX <= w_count_x) begin
                            w_ctl[gi].op = pol_pkg::CELL_LOWER;
                        end
                    end
                    if (w_do_del_pos && IDX >= w_del_pos && IDX1 < w_count_x) begin
                        w_ctl[gi].op = pol_pkg::CELL_UPPER;
                    end
                    // close the gap from the first match upward
                    if (w_do_del_val && w_hit[gi+1] && IDX1 < w_count_x) begin
                        w_ctl[gi].op = pol_pkg::CELL_UPPER;
                    end
                    if (w_do_update && IDX == w_pos_x) begin
                        w_ctl[gi].op = pol_pkg::CELL_LOAD;
                    end
                end
            end

            pol_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[gi]),
                .i_key   (w_key),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_hit   (w_hit[gi]),
                .o_data  (w_data[gi]),
                .o_hit   (w_hit[gi+1]),
                .o_first (w_first[gi])
            );
        end
    endgenerate

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word; hold while the m side stalls
    logic [XW-1:0] w_total_x;
    assign w_total_x = XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {2'b00, w_total_x[4:0], w_fidx, w_rd, w_status, w_success};
        end
    end

endmodule

@@ rtl/pol_chk.sv @@
// Port-level assertions for the positional ordered list unit, bound to the top level.
module pol_chk #(
    parameter int CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    localparam logic [4:0] CAP5 = 5'(CAPACITY);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // success and status agree
    a_succ_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[3:1] == pol_pkg::ST_OK)))
        else $error("success and status disagree");

    // a found index only comes with success
    a_fidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[40:36] != pol_pkg::NO_INDEX) |-> o_m_tdata[0])
        else $error("index reported on a failed action");

    // full is only reported on a full list
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3:1] == pol_pkg::ST_FULL) |-> (o_m_tdata[45:41] == CAP5))
        else $error("full reported below capacity");

    // reset empties the result side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind positional_ordered_list_unit pol_chk #(.CAPACITY(CAPACITY)) u_pol_chk (.*);

@@ verif/positional_ordered_list_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the positional ordered list unit: directed steps, then random traffic.
module positional_ordered_list_unit_tb;

    localparam int         LIST_DEPTH   = 16;
    localparam logic [2:0] ACT_RESERVED = 3'd7;   // undecoded action, must leave the list alone
    localparam int         RANDOM_WORDS = 800;
    localparam int         IDLE_LIMIT   = 1000;   // cycles with no handshake on either side
    localparam int         DRAIN_CYCLES = 8;

    // One request word, fields in natural order (packing into tdata is done by hand)
    typedef struct packed {
        logic [2:0]         action;
        logic               at_end;
        logic [3:0]         position;
        logic signed [31:0] value;
    } t_request;

    // One result word as the list should report it
    typedef struct packed {
        logic               success;
        logic [2:0]         status;
        logic signed [31:0] read_value;
        logic [4:0]         found_index;
        logic [4:0]         entry_total;
    } t_outcome;

    // One row of the directed script
    typedef struct packed {
        t_request req;
        logic [4:0] repeats;   // how many times to send the request
        logic       known;     // outcome below is written out, not predicted
        t_outcome   outcome;
    } t_step;

    // Outcomes that can be read straight off the list state
    localparam t_outcome UNTYPED       = '0;
    localparam t_outcome EMPTY_REFUSED = '{1'b0, pol_pkg::ST_EMPTY, 32'sd0,
                                           pol_pkg::NO_INDEX, 5'd0};
    localparam t_outcome DONE_EMPTY    = '{1'b1, pol_pkg::ST_OK, 32'sd0,
                                           pol_pkg::NO_INDEX, 5'd0};
    localparam t_outcome DONE_SINGLE   = '{1'b1, pol_pkg::ST_OK, 32'sd0,
                                           pol_pkg::NO_INDEX, 5'd1};

    localparam int SCRIPT_ROWS = 29;
    localparam t_step SCRIPT [SCRIPT_ROWS] = '{
        // empty list: every lookup or removal is refused, clear and the spare code pass
        '{'{pol_pkg::ACT_READ,       1'b0, 4'd0,  32'sd0},         5'd1,  1'b1, EMPTY_REFUSED},
        '{'{pol_pkg::ACT_REMOVE_POS, 1'b1, 4'd0,  32'sd0},         5'd1,  1'b1, EMPTY_REFUSED},
        '{'{pol_pkg::ACT_REMOVE_VAL, 1'b0, 4'd0,  32'sd0},         5'd1,  1'b1, EMPTY_REFUSED},
        '{'{pol_pkg::ACT_UPDATE,     1'b0, 4'd0,  32'sd1},         5'd1,  1'b1, EMPTY_REFUSED},
        '{'{pol_pkg::ACT_FIND,       1'b0, 4'd0,  32'sd0},         5'd1,  1'b1, EMPTY_REFUSED},
        '{'{pol_pkg::ACT_CLEAR,      1'b0, 4'd0,  32'sd0},         5'd1,  1'b1, DONE_EMPTY},
        '{'{ACT_RESERVED,            1'b1, 4'd15, -32'sd1},        5'd1,  1'b1, DONE_EMPTY},
        // first insert ignores the position
        '{'{pol_pkg::ACT_INSERT,     1'b0, 4'd15, 32'sh8000_0000}, 5'd1,  1'b1, DONE_SINGLE},
        // build [-1, 0, min, max, 5]: append by flag, at the head, in the middle, past the end
        '{'{pol_pkg::ACT_INSERT,     1'b1, 4'd0,  32'sh7FFF_FFFF}, 5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_INSERT,     1'b0, 4'd0,  -32'sd1},        5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_INSERT,     1'b0, 4'd1,  32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_INSERT,     1'b0, 4'd9,  32'sd5},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_READ,       1'b0, 4'd15, 32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_READ,       1'b0, 4'd2,  32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_FIND,       1'b0, 4'd0,  32'sh7FFF_FFFF}, 5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_FIND,       1'b0, 4'd0,  32'sd123},       5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_UPDATE,     1'b0, 4'd4,  32'sh5555_5555}, 5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_UPDATE,     1'b0, 4'd7,  32'sd9},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_REMOVE_POS, 1'b0, 4'd6,  32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_REMOVE_VAL, 1'b0, 4'd0,  32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_REMOVE_VAL, 1'b0, 4'd0,  32'sd99},        5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_REMOVE_POS, 1'b1, 4'd0,  32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_REMOVE_POS, 1'b0, 4'd0,  32'sd0},         5'd1,  1'b0, UNTYPED},
        // fill to capacity with duplicates, then push once more into the full list
        '{'{pol_pkg::ACT_INSERT,     1'b1, 4'd0,  32'shA5A5_0F0F}, 5'd14, 1'b0, UNTYPED},
        '{'{pol_pkg::ACT_INSERT,     1'b0, 4'd3,  32'sd1},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_FIND,       1'b0, 4'd0,  32'shA5A5_0F0F}, 5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_READ,       1'b0, 4'd15, 32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_REMOVE_POS, 1'b0, 4'd15, 32'sd0},         5'd1,  1'b0, UNTYPED},
        '{'{pol_pkg::ACT_CLEAR,      1'b0, 4'd0,  32'sd0},         5'd1,  1'b1, DONE_EMPTY}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // action[2:0], at_end[3], position[7:4], value[39:8]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // success[0], status[3:1], read_value[35:4],
                                    // found_index[40:36], entry_total[45:41]

    // Shadow copy of the list kept by the predictor
    logic signed [31:0] shadow_list [LIST_DEPTH];
    int                 shadow_len  = 0;

    t_outcome outcomes_due [$];     // predicted result words, oldest first
    int       mismatch_count = 0;
    int       hold_left      = 0;   // remaining cycles of the current result stall
    int       idle_cycles    = 0;
    logic     steady         = 1'b0; // no gaps on either side while set
    logic     growing        = 1'b1; // bias random traffic toward inserts

    positional_ordered_list_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Lowest live position holding v, or -1
    function automatic int first_position(logic signed [31:0] v);
        for (int i = 0; i < shadow_len; i++) begin
            if (shadow_list[i] == v) return i;
        end
        return -1;
    endfunction

    // Close the hole at position p
    function automatic void drop_entry(int p);
        for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
        shadow_len--;
    endfunction

    // Apply one action to the shadow list and return the word the block must produce
    function automatic t_outcome apply_list_action(t_request r);
        t_outcome o;
        int       p;
        int       hit;
        o.success     = 1'b1;
        o.status      = pol_pkg::ST_OK;
        o.read_value  = '0;
        o.found_index = pol_pkg::NO_INDEX;
        p = r.position;
        case (r.action) inside
            pol_pkg::ACT_INSERT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    o.success = 1'b0;
                    o.status  = pol_pkg::ST_FULL;
                end else begin
                    // append on the flag, past the end, or into an empty list
                    if (r.at_end || p >= shadow_len) p = shadow_len;
                    for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i - 1];
                    shadow_list[p] = r.value;
                    shadow_len++;
                end
            end
            pol_pkg::ACT_REMOVE_POS: begin
                if (shadow_len == 0) begin
                    o.success = 1'b0;
                    o.status  = pol_pkg::ST_EMPTY;
                end else begin
                    if (r.at_end) p = shadow_len - 1;
                    if (p >= shadow_len) begin
                        o.success = 1'b0;
                        o.status  = pol_pkg::ST_RANGE;
                    end else begin
                        drop_entry(p);
                    end
                end
            end
            pol_pkg::ACT_REMOVE_VAL, pol_pkg::ACT_FIND: begin
                if (shadow_len == 0) begin
                    o.success = 1'b0;
                    o.status  = pol_pkg::ST_EMPTY;
                end else begin
                    hit = first_position(r.value);
                    if (hit < 0) begin
                        o.success = 1'b0;
                        o.status  = pol_pkg::ST_NOTFOUND;
                    end else if (r.action == pol_pkg::ACT_REMOVE_VAL) begin
                        drop_entry(hit);
                    end else begin
                        o.found_index = 5'(hit);
                    end
                end
            end
            pol_pkg::ACT_UPDATE, pol_pkg::ACT_READ: begin
                if (shadow_len == 0) begin
                    o.success = 1'b0;
                    o.status  = pol_pkg::ST_EMPTY;
                end else if (p >= shadow_len) begin
                    o.success = 1'b0;
                    o.status  = pol_pkg::ST_RANGE;
                end else if (r.action == pol_pkg::ACT_UPDATE) begin
                    shadow_list[p] = r.value;
                end else begin
                    o.read_value = shadow_list[p];
                end
            end
            pol_pkg::ACT_CLEAR: shadow_len = 0;
            default: ;   // spare code: nothing moves, reports success
        endcase
        o.entry_total = 5'(shadow_len);
        return o;
    endfunction

    // Gap length for either side: mostly none or short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Random request shaped by the shadow list so that most actions hit live entries
    function automatic t_request build_request();
        t_request r;
        int       pick;
        int       span;
        pick = $urandom_range(0, 99);
        if (pick < (growing ? 55 : 20)) begin
            r.action = pol_pkg::ACT_INSERT;
        end else begin
            pick = $urandom_range(0, 59);
            if (pick < 12)      r.action = pol_pkg::ACT_REMOVE_POS;
            else if (pick < 22) r.action = pol_pkg::ACT_REMOVE_VAL;
            else if (pick < 32) r.action = pol_pkg::ACT_UPDATE;
            else if (pick < 44) r.action = pol_pkg::ACT_READ;
            else if (pick < 56) r.action = pol_pkg::ACT_FIND;
            else if (pick < 58) r.action = pol_pkg::ACT_CLEAR;
            else                r.action = ACT_RESERVED;
        end
        r.at_end = ($urandom_range(0, 3) == 0);
        // insert may also land one past the last entry
        span = (r.action == pol_pkg::ACT_INSERT) ? shadow_len : shadow_len - 1;
        if (span > 15) span = 15;
        if (span >= 0 && $urandom_range(0, 4) != 0) r.position = 4'($urandom_range(0, span));
        else                                         r.position = 4'($urandom_range(0, 15));
        if ((r.action == pol_pkg::ACT_REMOVE_VAL || r.action == pol_pkg::ACT_FIND)
                && shadow_len > 0 && $urandom_range(0, 9) < 7) begin
            r.value = shadow_list[$urandom_range(0, shadow_len - 1)];
        end else begin
            case ($urandom_range(0, 9)) inside
                0:       r.value = 32'sh8000_0000;
                1:       r.value = 32'sh7FFF_FFFF;
                2:       r.value = -32'sd1;
                3, 4:    r.value = 32'($urandom_range(0, 7));   // small pool breeds duplicates
                default: r.value = $urandom;
            endcase
        end
        return r;
    endfunction

    // Present one word, hold it until taken, then log its predicted outcome.
    // Returns in the step of the handshake with tvalid still high; the caller
    // either drives the next word or lowers tvalid before time moves on.
    task automatic send_request(input t_request r, input logic known, input t_outcome typed);
        int       gap;
        t_outcome predicted;
        gap = idle_span();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r.value, r.position, r.at_end, r.action};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        predicted = apply_list_action(r);
        if (known) predicted = typed;
        outcomes_due = {outcomes_due, predicted};
    endtask

    // Drop tvalid and hold the sender until every predicted word is back
    task automatic wait_for_outcomes();
        i_s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string field, input logic [47:0] got,
                                 input logic [47:0] want);
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_outcome(input logic [47:0] word);
        t_outcome want;
        if (outcomes_due.size() == 0) begin
            flag_mismatch("unexpected result word", word, '0);
            return;
        end
        want = outcomes_due.pop_front();
        if (word[0] !== want.success) begin
            flag_mismatch("success", 48'(word[0]), 48'(want.success));
        end
        if (word[3:1] !== want.status) begin
            flag_mismatch("status", 48'(word[3:1]), 48'(want.status));
        end
        if (word[35:4] !== want.read_value) begin
            flag_mismatch("read_value", 48'(word[35:4]), {16'd0, want.read_value});
        end
        if (word[40:36] !== want.found_index) begin
            flag_mismatch("found_index", 48'(word[40:36]), 48'(want.found_index));
        end
        if (word[45:41] !== want.entry_total) begin
            flag_mismatch("entry_total", 48'(word[45:41]), 48'(want.entry_total));
        end
    endtask

    // Result side: check every accepted word, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) check_outcome(o_m_tdata);
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_tready <= 1'b1;
            hold_left = idle_span();
        end
    end

    // Watchdog: any handshake on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready === 1'b1)
                || (o_m_tvalid === 1'b1 && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script
        for (int k = 0; k < SCRIPT_ROWS; k++) begin
            for (int n = 0; n < SCRIPT[k].repeats; n++) begin
                send_request(SCRIPT[k].req, SCRIPT[k].known, SCRIPT[k].outcome);
            end
        end
        wait_for_outcomes();

        // random traffic; grow and shrink phases walk the list between empty and full
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 100 == 0) steady = (k == 100) || ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0) growing = !growing;
            if (k == RANDOM_WORDS / 2) wait_for_outcomes();
            send_request(build_request(), 1'b0, UNTYPED);
        end
        wait_for_outcomes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list_unit.sv
rtl/pol_chk.sv
verif/positional_ordered_list_unit_tb.sv
